>>> sv/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the Cholesky correlated sampler
// Widths of the Q16.16 datapath, sequencer states and unit request struct.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int DEF_MAX_DIM = 32;
  localparam int DIM_W       = 6;
  localparam int ROW_W       = 5;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 72;   // 32 products of 64 bits, with sign and margin
  localparam int Q_FRAC      = 16;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_NOISE = 1'b1;

  localparam logic RK_FACTOR = 1'b0;
  localparam logic RK_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PIVOT = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_F_ROW,
    S_F_ROWA,
    S_F_COL,
    S_F_COLA,
    S_S_START,
    S_STREAM,
    S_DRAIN,
    S_F_ZERO,
    S_F_SQRT,
    S_F_DIV,
    S_PUSH
  } state_t;

  typedef enum logic [1:0] {
    M_DIAG,
    M_COL,
    M_SAMP
  } mode_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } ar_op_t;

  typedef struct packed {
    logic   start;
    ar_op_t op;
  } ar_req_t;

endpackage

>>> sv/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ccs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ccs_divsqrt.sv
// ----------------------------------------------------------------------------
// ccs_divsqrt: shared iterative square root and divider
// Square root: 64-bit radicand, 32 steps. Division: 63-bit dividend by a
// 32-bit divisor, restoring, one quotient bit per cycle, 63 steps.
// ----------------------------------------------------------------------------
module ccs_divsqrt import ccs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  ar_req_t       req,
  input  logic [63:0]   operand,
  input  logic [31:0]   divisor,
  output logic          busy,
  output logic          done,
  output logic [31:0]   root,
  output logic [62:0]   quot
);

  ar_op_t      op;
  logic [5:0]  cnt;
  logic [63:0] xr;
  logic [63:0] rr;
  logic [63:0] bm;
  logic [63:0] trial;
  logic [32:0] rem_sh;

  assign trial  = rr + bm;
  assign rem_sh = {rr[31:0], xr[62]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        rr   <= '0;
        if (req.op == OP_SQRT) begin
          xr  <= operand;
          bm  <= 64'h4000_0000_0000_0000;
          cnt <= 6'd31;
        end else begin
          xr  <= {1'b0, operand[62:0]};
          bm  <= {32'b0, divisor};
          cnt <= 6'd62;
        end
      end else if (busy) begin
        if (op == OP_SQRT) begin
          if (xr >= trial) begin
            xr <= xr - trial;
            rr <= (rr >> 1) + bm;
          end else begin
            rr <= rr >> 1;
          end
          bm <= bm >> 2;
        end else begin
          // quotient bits shift in as dividend bits shift out
          if (rem_sh >= bm[32:0]) begin
            rr <= {31'b0, rem_sh - bm[32:0]};
            xr <= {1'b0, xr[61:0], 1'b1};
          end else begin
            rr <= {31'b0, rem_sh};
            xr <= {1'b0, xr[61:0], 1'b0};
          end
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = rr[31:0];
  assign quot = xr[62:0];

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("unit restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finished operation");
  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    (done && op == OP_SQRT) |-> rr[63:32] == 32'b0)
    else $error("root wider than 32 bits");
`endif

endmodule

>>> sv/cholesky_correlated_sampler.sv
// ----------------------------------------------------------------------------
// cholesky_correlated_sampler: Cholesky factor and correlated normal sampler
// Stores a correlation matrix, factors it in place, then correlates samples.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel writes the matrix order (dimension), taken at any time,
//    to be changed only while the block is idle.
//  - in channel: kind 0 writes one lower-triangle entry (row, col, value);
//    last = 1 then runs the factorization, answered by one result with
//    result_kind 0 and status 1 if a pivot was clamped.
//  - kind 1 stores noise z[row] and answers with sum L[row][j]*z[j], j<=row,
//    saturated; rows at or beyond the dimension give no result.
//  - One item at a time: in_ready is high only while the sequencer is idle.
//    A result sits in an output register, so the next item is taken while
//    the receiver stalls; a second result then waits for the register.
//  - Samples: the one multiplier streams over the factor and noise RAMs
//    one product per cycle.
//  - Factorization: per column i the pivot root and each entry below it
//    come from the shared bit-serial square root and divider; a clamped
//    pivot instead zeroes the column.
//  - Reset idles the sequencer, sets dimension to 4 and clears the pivot
//    flag; the RAMs hold no reset state and need no clearing pass.
// ----------------------------------------------------------------------------
module cholesky_correlated_sampler import ccs_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [ROW_W-1:0]        row,
  input  logic [ROW_W-1:0]        col,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    result_kind,
  output logic [ROW_W-1:0]        index,
  output logic signed [VAL_W-1:0] result_value,
  output logic [1:0]              status
);

  localparam int DIM_LIMIT = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int CW        = $clog2(DIM_LIMIT + 1);
  localparam int RW        = $clog2(MAX_DIM);
  localparam int FD        = MAX_DIM * MAX_DIM;
  localparam int FAW       = $clog2(FD);

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] NUM_HI   = {{(ACC_W-47){1'b0}}, 1'b1, 46'b0};
  localparam logic signed [ACC_W-1:0] NUM_LO   = -NUM_HI;
  localparam logic signed [ACC_W-1:0] S32_MAX  = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] S32_MIN  = {{(ACC_W-31){1'b1}}, 31'b0};

  function automatic logic [FAW-1:0] faddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return FAW'(r) * FAW'(MAX_DIM) + FAW'(c);
  endfunction

  state_t state, state_next;
  mode_t  mode;

  logic [DIM_W-1:0] dimension;
  logic             pivot_flag;
  logic [CW-1:0]    n;
  logic [CW-1:0]    i, j, k, k_d, cnt, srow;
  logic signed [VAL_W-1:0] aval;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic                    rd_v, mul_v;
  logic [31:0]             piv;
  logic                    q_neg;

  logic             res_kind;
  logic [ROW_W-1:0] res_index;
  logic [VAL_W-1:0] res_value;
  status_t          res_status;

  // RAM ports
  logic             fac_we;
  logic [FAW-1:0]   fac_waddr, fac_raddr;
  logic [31:0]      fac_wdata, fac_rd;
  logic             nz_we;
  logic [RW-1:0]    nz_waddr, nz_raddr;
  logic [31:0]      nz_rd;
  logic             rb_we;
  logic [RW-1:0]    rb_waddr, rb_raddr;
  logic [31:0]      rb_rd;

  ar_req_t     ar_req;
  logic [63:0] ar_operand;
  logic        ar_busy, ar_done;
  logic [31:0] ar_root;
  logic [62:0] ar_quot;

  logic                    in_fire;
  logic                    load_ok, noise_ok;
  logic                    pipe_empty;
  logic signed [ACC_W-1:0] rsum, diff, num, num_mag;
  logic                    diff_pos;
  logic [CW-1:0]           rsel;
  logic [31:0]             opb;
  logic [31:0]             q_sat;
  logic [31:0]             s_val;
  logic                    s_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (dimension == '0) begin
      n = CW'(1);
    end else if (32'(dimension) > DIM_LIMIT) begin
      n = CW'(DIM_LIMIT);
    end else begin
      n = CW'(dimension);
    end
  end

  assign load_ok    = (32'(row) < DIM_LIMIT) && (col <= row);
  assign noise_ok   = (32'(row) < 32'(n));
  assign pipe_empty = !rd_v && !mul_v;

  // round half up to Q16.16, then subtract from the stored entry
  assign rsum     = (acc + HALF_LSB) >>> Q_FRAC;
  assign diff     = ACC_W'(aval) - rsum;
  assign diff_pos = !diff[ACC_W-1] && (diff != '0);

  always_comb begin
    if (diff > NUM_HI) begin
      num = NUM_HI;
    end else if (diff < NUM_LO) begin
      num = NUM_LO;
    end else begin
      num = diff;
    end
    num_mag = num[ACC_W-1] ? -num : num;
  end

  always_comb begin
    if (!q_neg) begin
      q_sat = (ar_quot > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF : ar_quot[31:0];
    end else begin
      q_sat = (ar_quot > 63'h8000_0000) ? 32'h8000_0000 : -ar_quot[31:0];
    end
  end

  always_comb begin
    s_sat = 1'b0;
    s_val = rsum[31:0];
    if (rsum > S32_MAX) begin
      s_sat = 1'b1;
      s_val = 32'h7FFF_FFFF;
    end else if (rsum < S32_MIN) begin
      s_sat = 1'b1;
      s_val = 32'h8000_0000;
    end
  end

  always_comb begin
    unique case (mode)
      M_DIAG:  begin rsel = i;    opb = fac_rd; end
      M_COL:   begin rsel = j;    opb = rb_rd;  end
      M_SAMP:  begin rsel = srow; opb = nz_rd;  end
      default: begin rsel = i;    opb = fac_rd; end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (kind == KIND_LOAD) begin
            if (last) state_next = S_F_ROW;
          end else if (noise_ok) begin
            state_next = S_S_START;
          end
        end
      end
      S_F_ROW:   state_next = (i == n) ? S_PUSH : S_F_ROWA;
      S_F_ROWA:  state_next = (i == '0) ? S_DRAIN : S_STREAM;
      S_F_COL:   state_next = (j == n) ? S_F_ROW : S_F_COLA;
      S_F_COLA:  state_next = (i == '0) ? S_DRAIN : S_STREAM;
      S_S_START: state_next = S_STREAM;
      S_STREAM:  if (k == cnt - CW'(1)) state_next = S_DRAIN;
      S_DRAIN: begin
        if (pipe_empty) begin
          unique case (mode)
            M_DIAG:  state_next = diff_pos ? S_F_SQRT : S_F_ZERO;
            M_COL:   state_next = S_F_DIV;
            M_SAMP:  state_next = S_PUSH;
            default: state_next = S_PUSH;
          endcase
        end
      end
      S_F_ZERO:  if (j == n) state_next = S_F_ROW;
      S_F_SQRT:  if (ar_done) state_next = S_F_COL;
      S_F_DIV:   if (ar_done) state_next = S_F_COL;
      S_PUSH:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // RAM and unit controls
  always_comb begin
    fac_we     = 1'b0;
    fac_waddr  = faddr(i, i);
    fac_wdata  = '0;
    fac_raddr  = faddr(i, i);
    nz_we      = 1'b0;
    nz_waddr   = RW'(row);
    nz_raddr   = RW'(k);
    rb_we      = rd_v && (mode == M_DIAG);
    rb_waddr   = RW'(k_d);
    rb_raddr   = RW'(k);
    ar_req     = '{start: 1'b0, op: OP_SQRT};
    ar_operand = {diff[47:0], 16'b0};
    unique case (state)
      S_IDLE: begin
        if (in_fire && kind == KIND_LOAD && load_ok) begin
          fac_we    = 1'b1;
          fac_waddr = faddr(CW'(row), CW'(col));
          fac_wdata = value;
        end
        nz_we = in_fire && (kind == KIND_NOISE) && noise_ok;
      end
      S_F_COL:  fac_raddr = faddr(j, i);
      S_STREAM: fac_raddr = faddr(rsel, k);
      S_DRAIN: begin
        if (pipe_empty && mode == M_DIAG) begin
          if (diff_pos) begin
            ar_req = '{start: 1'b1, op: OP_SQRT};
          end else begin
            fac_we = 1'b1;
          end
        end else if (pipe_empty && mode == M_COL) begin
          ar_req     = '{start: 1'b1, op: OP_DIV};
          ar_operand = {1'b0, num_mag[46:0], 16'b0};
        end
      end
      S_F_ZERO: begin
        fac_we    = (j != n);
        fac_waddr = faddr(j, i);
      end
      S_F_SQRT: begin
        fac_we    = ar_done;
        fac_wdata = ar_root;
      end
      S_F_DIV: begin
        fac_we    = ar_done;
        fac_waddr = faddr(j, i);
        fac_wdata = q_sat;
      end
      default: ;
    endcase
  end

  // multiply-accumulate pipeline: read, product, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= (state == S_STREAM);
      mul_v <= rd_v;
    end
    k_d <= k;
    if (rd_v) begin
      prod <= $signed(fac_rd) * $signed(opb);
    end
    if (state == S_F_ROWA || state == S_F_COLA || state == S_S_START) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dimension  <= DIM_W'(4);
      pivot_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        dimension <= cfg_data;
      end
      // a new result loads in S_PUSH, which keeps out_valid high itself
      if (out_valid && out_ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && kind == KIND_LOAD && last) begin
            pivot_flag <= 1'b0;
            i          <= '0;
          end
          if (in_fire && kind == KIND_NOISE && noise_ok) begin
            srow <= CW'(row);
          end
        end
        S_F_ROW: begin
          res_kind   <= RK_FACTOR;
          res_index  <= '0;
          res_value  <= '0;
          res_status <= pivot_flag ? ST_PIVOT : ST_OK;
        end
        S_F_ROWA: begin
          aval <= fac_rd;
          k    <= '0;
          cnt  <= i;
          mode <= M_DIAG;
        end
        S_F_COL: begin
          if (j == n) i <= i + CW'(1);
        end
        S_F_COLA: begin
          aval <= fac_rd;
          k    <= '0;
          cnt  <= i;
          mode <= M_COL;
        end
        S_S_START: begin
          k    <= '0;
          cnt  <= srow + CW'(1);
          mode <= M_SAMP;
        end
        S_STREAM: k <= k + CW'(1);
        S_DRAIN: begin
          if (pipe_empty) begin
            unique case (mode)
              M_DIAG: begin
                if (!diff_pos) begin
                  pivot_flag <= 1'b1;
                  j          <= i + CW'(1);
                end
              end
              M_COL:  q_neg <= num[ACC_W-1];
              M_SAMP: begin
                res_kind   <= RK_SAMPLE;
                res_index  <= ROW_W'(srow);
                res_value  <= s_val;
                res_status <= s_sat ? ST_SAT : (pivot_flag ? ST_PIVOT : ST_OK);
              end
              default: ;
            endcase
          end
        end
        S_F_ZERO: begin
          if (j == n) begin
            i <= i + CW'(1);
          end else begin
            j <= j + CW'(1);
          end
        end
        S_F_SQRT: begin
          if (ar_done) begin
            piv <= ar_root;
            j   <= i + CW'(1);
          end
        end
        S_F_DIV: begin
          if (ar_done) j <= j + CW'(1);
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_kind  <= res_kind;
            index        <= res_index;
            result_value <= res_value;
            status       <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

  ccs_ram #(.WIDTH(32), .DEPTH(FD)) u_factor (
    .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
    .raddr(fac_raddr), .rdata(fac_rd)
  );

  ccs_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_noise (
    .clk(clk), .we(nz_we), .waddr(nz_waddr), .wdata(value),
    .raddr(nz_raddr), .rdata(nz_rd)
  );

  // copy of pivot row i, read alongside row j for the column updates
  ccs_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_rowbuf (
    .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(fac_rd),
    .raddr(rb_raddr), .rdata(rb_rd)
  );

  ccs_divsqrt u_divsqrt (
    .clk(clk), .rst(rst), .req(ar_req), .operand(ar_operand), .divisor(piv),
    .busy(ar_busy), .done(ar_done), .root(ar_root), .quot(ar_quot)
  );

`ifndef NO_ASSERTIONS
  a_no_write_in_stream: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |-> !fac_we)
    else $error("factor write while streaming reads");
  a_rd_follows_stream: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state) == S_STREAM)
    else $error("read valid without an issued read");
  a_unit_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    ar_req.start |-> !ar_busy)
    else $error("arithmetic unit started while busy");
  a_factor_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == RK_FACTOR) |-> index == '0 && result_value == '0)
    else $error("factorization result with payload");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");
`endif

endmodule
